>>> design/atilt_pkg.sv
// ----------------------------------------------------------------------------
// atilt_pkg: shared types and constants for the tilt angle pipeline
// Fixed-point widths, atan polynomial coefficients and output codes.
// ----------------------------------------------------------------------------
package atilt_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int FRAC_BITS   = 24;

	// square root: 16 integer digits plus one digit per fraction bit
	localparam int SQ_STEPS = 16 + FRAC_BITS;
	localparam int N_W      = 32;
	localparam int ROOT_W   = 16 + FRAC_BITS;
	localparam int REM_W    = ROOT_W + 2;

	// atan operands
	localparam int X_W      = SAMPLE_BITS + FRAC_BITS + 1;
	localparam int D_W      = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int DV_STEPS = FRAC_BITS + 1;
	localparam int Q_W      = FRAC_BITS + 1;
	localparam int ANG_W    = FRAC_BITS + 3;

	// scaling to tenths of a degree
	localparam int SCALE_W  = 30;
	localparam int PROD_W   = ANG_W - 1 + SCALE_W;
	localparam int V_W      = PROD_W - FRAC_BITS;
	localparam int RECIP_K  = 51;
	localparam int MAG_W    = V_W + 32 - RECIP_K;
	localparam int RES_W    = MAG_W + 3;
	localparam int OUT_W    = 12;

	localparam logic [Q_W-1:0] C_CUBE =
		Q_W'(((64'd1963 << FRAC_BITS) + 64'd5000) / 64'd10000);
	localparam logic [Q_W-1:0] C_LIN =
		Q_W'(((64'd9817 << FRAC_BITS) + 64'd5000) / 64'd10000);
	localparam logic signed [ANG_W-1:0] Q_ONE =
		ANG_W'(((64'd785398 << FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic signed [ANG_W-1:0] Q_THREE =
		ANG_W'(((64'd2356194 << FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic [SCALE_W-1:0] SCALE_NUM = SCALE_W'(572957795);
	localparam logic [31:0] RECIP_M =
		32'(((64'd1 << RECIP_K) + 64'd999999) / 64'd1000000);

	localparam logic signed [RES_W-1:0] CENTER = RES_W'(1800);
	localparam logic signed [RES_W-1:0] TOP    = RES_W'(3600);
	localparam logic [OUT_W-1:0] INVALID_CODE  = OUT_W'(999);
	localparam logic [OUT_W-1:0] TOP_CODE      = OUT_W'(3600);

	typedef enum logic [1:0] {
		OP_TILT_X,
		OP_TILT_Y,
		OP_ROLL_Z,
		OP_INVALID
	} op_t;

	// sideband that rides along the square root stages
	typedef struct packed {
		op_t                           op;
		logic                          yneg;
		logic [SAMPLE_BITS-1:0]        ymag;
		logic signed [X_W-1:0]         xq;
	} side_t;

	// sideband that rides along the divider and multiplier stages
	typedef struct packed {
		op_t  op;
		logic yneg;
		logic xneg;
	} meta_t;

endpackage

>>> design/accel_tilt_angle.sv
// ----------------------------------------------------------------------------
// accel_tilt_angle: tilt angle from a three-axis accelerometer sample
// Square root, atan2 approximation and scaling in one stall-able pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one word: operation select and
//   the x, y, z samples. Output channel out_valid/out_ready carries one word
//   per input word: angle_tenths, the angle in tenths of a degree offset by
//   1800 and saturated to 0..3600, or 999 for the invalid select.
//   From accept to out_valid a word passes one input stage, one
//   stage per square root digit (40), one operand stage, one stage per
//   quotient bit (25), six multiply and scaling stages, one output register.
//   One word per cycle unless stalled; every stage is a register slice.
//   All stages advance together whenever the output register is empty or
//   being taken; a stalled receiver freezes the whole pipeline, in_ready
//   drops in the same cycle and no word is lost or repeated.
//   Reset clears every stage valid bit; the pipeline comes out empty.
// ----------------------------------------------------------------------------
module accel_tilt_angle (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [1:0]                                operation,
	input  logic signed [atilt_pkg::SAMPLE_BITS-1:0]  accel_x,
	input  logic signed [atilt_pkg::SAMPLE_BITS-1:0]  accel_y,
	input  logic signed [atilt_pkg::SAMPLE_BITS-1:0]  accel_z,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [atilt_pkg::OUT_W-1:0]               angle_tenths
);
	import atilt_pkg::*;

	logic adv;

	// input stage: squares and operand selection
	op_t                        op_in;
	logic signed [2*SAMPLE_BITS-1:0] sq_a, sq_b;
	logic signed [SAMPLE_BITS:0] yv;
	logic [N_W-1:0]             n_in;
	side_t                      side_in;

	// square root stages
	logic [SQ_STEPS:0]          sq_vld_s;
	logic [N_W-1:0]             sq_n_s    [SQ_STEPS+1];
	logic [ROOT_W-1:0]          sq_root_s [SQ_STEPS+1];
	logic [REM_W-1:0]           sq_rem_s  [SQ_STEPS+1];
	side_t                      sq_side_s [SQ_STEPS+1];
	logic [N_W-1:0]             sq_n_d    [SQ_STEPS];
	logic [ROOT_W-1:0]          sq_root_d [SQ_STEPS];
	logic [REM_W-1:0]           sq_rem_d  [SQ_STEPS];
	logic [REM_W-1:0]           sq_sh     [SQ_STEPS];
	logic [REM_W-1:0]           sq_trial  [SQ_STEPS];

	// operand stage
	logic signed [X_W-1:0]      x_sel;
	logic signed [D_W-1:0]      x_ext, a_val, num_v, den_v;
	meta_t                      meta_pr;

	// divider stages
	logic [DV_STEPS:0]          dv_vld_s;
	logic [D_W-1:0]             dv_rem_s  [DV_STEPS+1];
	logic [D_W-2:0]             dv_den_s  [DV_STEPS+1];
	logic [Q_W-1:0]             dv_q_s    [DV_STEPS+1];
	logic                       dv_rneg_s [DV_STEPS+1];
	meta_t                      dv_meta_s [DV_STEPS+1];
	logic [D_W-1:0]             dv_rem_d  [DV_STEPS];
	logic [Q_W-1:0]             dv_q_d    [DV_STEPS];
	logic [D_W-1:0]             dv_sh     [DV_STEPS];
	logic [Q_W-1:0]             dv_qsh    [DV_STEPS];

	// polynomial and scaling stages
	logic                       vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic [Q_W-1:0]             rmag_s3, rmag_s4, r2_s3, t_s4, corr_s5;
	logic                       rneg_s3, rneg_s4, rneg_s5;
	meta_t                      meta_s3, meta_s4, meta_s5;
	logic [2*Q_W-1:0]           p_r2, p_t, p_corr;
	logic [Q_W-1:0]             d_lin;
	logic signed [ANG_W-1:0]    ang_base, ang_v, ang_s;
	logic [ANG_W-2:0]           mag_s6;
	logic                       neg_s6, neg_s7, neg_s8;
	op_t                        op_s6, op_s7, op_s8;
	logic [PROD_W-1:0]          p_scale;
	logic [V_W-1:0]             v_s7;
	logic [V_W+31:0]            p_recip;
	logic [MAG_W-1:0]           mag_s8;
	logic signed [RES_W-1:0]    res_v;
	logic [OUT_W-1:0]           res_code;

	// output register
	logic                       out_valid_q;
	logic [OUT_W-1:0]           out_angle_q;
	op_t                        out_op_q;

	// advance every stage when the output slot is free or being taken
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// select the angle operands for the incoming word
	always_comb begin
		op_in = op_t'(operation);
		sq_a  = accel_x * accel_x;
		sq_b  = accel_z * accel_z;
		yv    = {accel_y[SAMPLE_BITS-1], accel_y};
		unique case (op_in)
			OP_TILT_X: begin
				yv = {accel_y[SAMPLE_BITS-1], accel_y};
			end
			OP_TILT_Y: begin
				sq_a = accel_y * accel_y;
				yv   = {accel_x[SAMPLE_BITS-1], accel_x};
			end
			OP_ROLL_Z: begin
				yv = -{accel_y[SAMPLE_BITS-1], accel_y};
			end
			OP_INVALID: begin
				yv = {accel_y[SAMPLE_BITS-1], accel_y};
			end
		endcase
		n_in         = N_W'($unsigned(sq_a)) + N_W'($unsigned(sq_b));
		side_in.op   = op_in;
		side_in.yneg = yv[SAMPLE_BITS];
		side_in.ymag = yv[SAMPLE_BITS] ? SAMPLE_BITS'(-yv) : SAMPLE_BITS'(yv);
		side_in.xq   = $signed({accel_z[SAMPLE_BITS-1], accel_z, {FRAC_BITS{1'b0}}});
	end

	// one square root digit per stage
	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			sq_sh[k]    = {sq_rem_s[k][REM_W-3:0], sq_n_s[k][N_W-1 -: 2]};
			sq_trial[k] = {sq_root_s[k], 2'b01};
			sq_n_d[k]   = sq_n_s[k] << 2;
			if (sq_sh[k] >= sq_trial[k]) begin
				sq_rem_d[k]  = sq_sh[k] - sq_trial[k];
				sq_root_d[k] = {sq_root_s[k][ROOT_W-2:0], 1'b1};
			end else begin
				sq_rem_d[k]  = sq_sh[k];
				sq_root_d[k] = {sq_root_s[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	// octant ratio operands
	always_comb begin
		x_sel = (sq_side_s[SQ_STEPS].op == OP_ROLL_Z) ? sq_side_s[SQ_STEPS].xq
			: $signed({1'b0, sq_root_s[SQ_STEPS][X_W-2:0]});
		x_ext = $signed({x_sel[X_W-1], x_sel});
		a_val = $signed({2'b00, sq_side_s[SQ_STEPS].ymag, {FRAC_BITS{1'b0}}})
			+ D_W'(1);
		if (x_sel[X_W-1]) begin
			num_v = x_ext + a_val;
			den_v = a_val - x_ext;
		end else begin
			num_v = x_ext - a_val;
			den_v = x_ext + a_val;
		end
		meta_pr.op   = sq_side_s[SQ_STEPS].op;
		meta_pr.yneg = sq_side_s[SQ_STEPS].yneg;
		meta_pr.xneg = x_sel[X_W-1];
	end

	// one quotient bit per stage, the integer bit first
	always_comb begin
		for (int k = 0; k < DV_STEPS; k++) begin
			if (k == 0) begin
				dv_sh[k]  = dv_rem_s[k];
				dv_qsh[k] = dv_q_s[k];
			end else begin
				dv_sh[k]  = dv_rem_s[k] << 1;
				dv_qsh[k] = dv_q_s[k] << 1;
			end
			if (dv_sh[k] >= {1'b0, dv_den_s[k]}) begin
				dv_rem_d[k] = dv_sh[k] - {1'b0, dv_den_s[k]};
				dv_q_d[k]   = dv_qsh[k] | Q_W'(1);
			end else begin
				dv_rem_d[k] = dv_sh[k];
				dv_q_d[k]   = dv_qsh[k];
			end
		end
	end

	// polynomial products, angle and scaling
	always_comb begin
		p_r2     = dv_q_s[DV_STEPS] * dv_q_s[DV_STEPS];
		p_t      = C_CUBE * r2_s3;
		d_lin    = C_LIN - t_s4;
		p_corr   = d_lin * rmag_s4;
		ang_base = meta_s5.xneg ? Q_THREE : Q_ONE;
		ang_v    = rneg_s5 ? ang_base + $signed({2'b00, corr_s5})
			: ang_base - $signed({2'b00, corr_s5});
		ang_s    = meta_s5.yneg ? -ang_v : ang_v;
		p_scale  = mag_s6 * SCALE_NUM;
		p_recip  = v_s7 * RECIP_M;
		res_v    = neg_s8 ? CENTER - $signed({3'b000, mag_s8})
			: CENTER + $signed({3'b000, mag_s8});
		priority if (op_s8 == OP_INVALID) begin
			res_code = INVALID_CODE;
		end else if (res_v < 0) begin
			res_code = '0;
		end else if (res_v > TOP) begin
			res_code = TOP_CODE;
		end else begin
			res_code = OUT_W'(res_v);
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s    <= '0;
			dv_vld_s    <= '0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			vld_s8      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			sq_vld_s    <= {sq_vld_s[SQ_STEPS-1:0], in_valid};
			dv_vld_s    <= {dv_vld_s[DV_STEPS-1:0], sq_vld_s[SQ_STEPS]};
			vld_s3      <= dv_vld_s[DV_STEPS];
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			vld_s7      <= vld_s6;
			vld_s8      <= vld_s7;
			out_valid_q <= vld_s8;
		end
	end

	// stage payload, held while stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_n_s[0]    <= n_in;
			sq_root_s[0] <= '0;
			sq_rem_s[0]  <= '0;
			sq_side_s[0] <= side_in;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_n_s[k+1]    <= sq_n_d[k];
				sq_root_s[k+1] <= sq_root_d[k];
				sq_rem_s[k+1]  <= sq_rem_d[k];
				sq_side_s[k+1] <= sq_side_s[k];
			end
			dv_rem_s[0]  <= num_v[D_W-1] ? D_W'(-num_v) : D_W'(num_v);
			dv_den_s[0]  <= den_v[D_W-2:0];
			dv_q_s[0]    <= '0;
			dv_rneg_s[0] <= num_v[D_W-1];
			dv_meta_s[0] <= meta_pr;
			for (int k = 0; k < DV_STEPS; k++) begin
				dv_rem_s[k+1]  <= dv_rem_d[k];
				dv_den_s[k+1]  <= dv_den_s[k];
				dv_q_s[k+1]    <= dv_q_d[k];
				dv_rneg_s[k+1] <= dv_rneg_s[k];
				dv_meta_s[k+1] <= dv_meta_s[k];
			end
			rmag_s3     <= dv_q_s[DV_STEPS];
			r2_s3       <= p_r2[FRAC_BITS +: Q_W];
			rneg_s3     <= dv_rneg_s[DV_STEPS];
			meta_s3     <= dv_meta_s[DV_STEPS];
			rmag_s4     <= rmag_s3;
			t_s4        <= p_t[FRAC_BITS +: Q_W];
			rneg_s4     <= rneg_s3;
			meta_s4     <= meta_s3;
			corr_s5     <= p_corr[FRAC_BITS +: Q_W];
			rneg_s5     <= rneg_s4;
			meta_s5     <= meta_s4;
			mag_s6      <= ang_s[ANG_W-1] ? (ANG_W-1)'(-ang_s) : (ANG_W-1)'(ang_s);
			neg_s6      <= (meta_s5.op != OP_TILT_X) ^ ang_s[ANG_W-1];
			op_s6       <= meta_s5.op;
			v_s7        <= p_scale[FRAC_BITS +: V_W];
			neg_s7      <= neg_s6;
			op_s7       <= op_s6;
			mag_s8      <= p_recip[RECIP_K +: MAG_W];
			neg_s8      <= neg_s7;
			op_s8       <= op_s7;
			out_angle_q <= res_code;
			out_op_q    <= op_s8;
		end
	end

	assign out_valid    = out_valid_q;
	assign angle_tenths = out_angle_q;

`ifndef SYNTH
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_tenths <= TOP_CODE)
		else $error("angle out of range");

	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_op_q == OP_INVALID) |-> angle_tenths == INVALID_CODE)
		else $error("invalid select must give the invalid code");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(sq_vld_s) && $stable(dv_vld_s) && $stable(vld_s8))
		else $error("pipeline moved during a stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> !in_ready || out_ready || !out_valid)
		else $error("output slot overwritten");
`endif

endmodule
